[rtl/oate_pkg.sv]
`timescale 1ns / 1ps

package oate_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int FPOS_W   = 4;
  localparam int COUNT_W  = 5;

  // width that holds both a position and a count for compares
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [AW-1:0]     addr_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_REMOVE = 3'd4,
    MODE_FIND   = 3'd5,
    MODE_READ   = 3'd6
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    status_e status;
    data_t   data;
    addr_t   fpos;
    cnt_t    count;
  } result_t;

endpackage

[rtl/oate_mem.sv]
`timescale 1ns / 1ps

module oate_mem (
  input  logic              clk_i,
  input  oate_pkg::mem_req_t req_i,
  output oate_pkg::data_t   rdata_o
);

  oate_pkg::data_t mem [oate_pkg::CAPACITY];
  oate_pkg::data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/oate_ctrl.sv]
`timescale 1ns / 1ps

module oate_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [oate_pkg::MODE_W-1:0]    mode_i,
  input  logic [oate_pkg::POS_W-1:0]     position_i,
  input  logic signed [oate_pkg::DATA_W-1:0] operand_value_i,
  output oate_pkg::mem_req_t             mem_req_o,
  input  oate_pkg::data_t                mem_rdata_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output oate_pkg::result_t              res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIXUP,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  oate_pkg::mode_e   op_q, op_d;
  oate_pkg::data_t   val_q, val_d;
  oate_pkg::addr_t   pos_q, pos_d;
  oate_pkg::addr_t   rp_q, rp_d;
  oate_pkg::cnt_t    rd_left_q, rd_left_d;
  logic              pend_q, pend_d;
  oate_pkg::addr_t   pidx_q, pidx_d;
  oate_pkg::cnt_t    k_q, k_d;
  oate_pkg::cnt_t    count_q, count_d;
  oate_pkg::status_e st_q, st_d;
  oate_pkg::data_t   data_q, data_d;
  oate_pkg::addr_t   fpos_q, fpos_d;

  logic [oate_pkg::CMP_W-1:0] pos_c, n_c;
  oate_pkg::addr_t pos_a;
  oate_pkg::cnt_t  k_next;
  logic            eq, last;

  assign pos_c  = oate_pkg::CMP_W'(position_i);
  assign n_c    = oate_pkg::CMP_W'(count_q);
  assign pos_a  = oate_pkg::AW'(position_i);
  assign eq     = (mem_rdata_i == val_q);
  assign last   = (rd_left_q == '0);
  assign k_next = eq ? k_q : k_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    pos_d     = pos_q;
    rp_d      = rp_q;
    rd_left_d = rd_left_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    k_d       = k_q;
    count_d   = count_q;
    st_d      = st_q;
    data_d    = data_q;
    fpos_d    = fpos_q;
    mem_req_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = oate_pkg::mode_e'(mode_i);
          val_d   = operand_value_i;
          pos_d   = pos_a;
          st_d    = oate_pkg::ST_OK;
          data_d  = '0;
          fpos_d  = '0;
          k_d     = '0;
          pend_d  = 1'b0;
          state_d = S_DONE;
          unique case (mode_i)
            oate_pkg::MODE_PUSH: begin
              if (count_q == oate_pkg::CNT_W'(oate_pkg::CAPACITY)) begin
                st_d = oate_pkg::ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = oate_pkg::AW'(count_q);
                mem_req_o.wdata = operand_value_i;
                count_d         = count_q + 1'b1;
              end
            end
            oate_pkg::MODE_POP: begin
              if (count_q == '0) begin
                st_d = oate_pkg::ST_EMPTY;
              end else begin
                rp_d      = oate_pkg::AW'(count_q - 1'b1);
                rd_left_d = oate_pkg::CNT_W'(1);
                state_d   = S_SCAN;
              end
            end
            oate_pkg::MODE_INSERT: begin
              if (pos_c > n_c) begin
                st_d = oate_pkg::ST_RANGE;
              end else if (count_q == oate_pkg::CNT_W'(oate_pkg::CAPACITY)) begin
                st_d = oate_pkg::ST_FULL;
              end else if (pos_c == n_c) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = pos_a;
                mem_req_o.wdata = operand_value_i;
                count_d         = count_q + 1'b1;
              end else begin
                // walk the tail downward, then drop the value in at the end
                rp_d      = oate_pkg::AW'(count_q - 1'b1);
                rd_left_d = oate_pkg::CNT_W'(n_c - pos_c);
                state_d   = S_SCAN;
              end
            end
            oate_pkg::MODE_DELETE: begin
              if (pos_c >= n_c) begin
                st_d = oate_pkg::ST_RANGE;
              end else if (pos_c == n_c - 1'b1) begin
                count_d = count_q - 1'b1;
              end else begin
                rp_d      = pos_a + 1'b1;
                rd_left_d = oate_pkg::CNT_W'(n_c - pos_c - 1'b1);
                state_d   = S_SCAN;
              end
            end
            oate_pkg::MODE_REMOVE, oate_pkg::MODE_FIND: begin
              if (count_q == '0) begin
                st_d = oate_pkg::ST_NOTFOUND;
              end else begin
                st_d      = oate_pkg::ST_NOTFOUND;
                rp_d      = '0;
                rd_left_d = count_q;
                state_d   = S_SCAN;
              end
            end
            oate_pkg::MODE_READ: begin
              if (pos_c >= n_c) begin
                st_d = oate_pkg::ST_RANGE;
              end else begin
                rp_d      = pos_a;
                rd_left_d = oate_pkg::CNT_W'(1);
                state_d   = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // one read issued per cycle, its word arrives the cycle after
        if (rd_left_q != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = rp_q;
          rp_d            = (op_q == oate_pkg::MODE_INSERT) ? rp_q - 1'b1 : rp_q + 1'b1;
          rd_left_d       = rd_left_q - 1'b1;
        end
        pend_d = (rd_left_q != '0);
        pidx_d = rp_q;

        if (pend_q) begin
          unique case (op_q)
            oate_pkg::MODE_POP: begin
              data_d  = mem_rdata_i;
              count_d = count_q - 1'b1;
              state_d = S_DONE;
            end
            oate_pkg::MODE_READ: begin
              data_d  = mem_rdata_i;
              state_d = S_DONE;
            end
            oate_pkg::MODE_FIND: begin
              if (eq) begin
                st_d    = oate_pkg::ST_OK;
                fpos_d  = pidx_q;
                state_d = S_DONE;
              end else if (last) begin
                state_d = S_DONE;
              end
            end
            oate_pkg::MODE_REMOVE: begin
              // compact survivors toward the front
              if (!eq) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = oate_pkg::AW'(k_q);
                mem_req_o.wdata = mem_rdata_i;
              end
              k_d = k_next;
              if (last) begin
                count_d = k_next;
                st_d    = (k_next == count_q) ? oate_pkg::ST_NOTFOUND : oate_pkg::ST_OK;
                state_d = S_DONE;
              end
            end
            oate_pkg::MODE_DELETE: begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = pidx_q - 1'b1;
              mem_req_o.wdata = mem_rdata_i;
              if (last) begin
                count_d = count_q - 1'b1;
                state_d = S_DONE;
              end
            end
            oate_pkg::MODE_INSERT: begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = pidx_q + 1'b1;
              mem_req_o.wdata = mem_rdata_i;
              if (last) begin
                state_d = S_FIXUP;
              end
            end
            default: state_d = S_DONE;
          endcase
        end

        if (state_d != S_SCAN) begin
          pend_d    = 1'b0;
          rd_left_d = '0;
        end
      end

      S_FIXUP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q;
        mem_req_o.wdata = val_q;
        count_d         = count_q + 1'b1;
        state_d         = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= oate_pkg::MODE_PUSH;
      val_q     <= '0;
      pos_q     <= '0;
      rp_q      <= '0;
      rd_left_q <= '0;
      pend_q    <= 1'b0;
      pidx_q    <= '0;
      k_q       <= '0;
      count_q   <= '0;
      st_q      <= oate_pkg::ST_OK;
      data_q    <= '0;
      fpos_q    <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      val_q     <= val_d;
      pos_q     <= pos_d;
      rp_q      <= rp_d;
      rd_left_q <= rd_left_d;
      pend_q    <= pend_d;
      pidx_q    <= pidx_d;
      k_q       <= k_d;
      count_q   <= count_d;
      st_q      <= st_d;
      data_q    <= data_d;
      fpos_q    <= fpos_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_o.status = st_q;
  assign res_o.data   = data_q;
  assign res_o.fpos   = fpos_q;
  assign res_o.count  = count_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= oate_pkg::CNT_W'(oate_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we && mem_req_o.re) |-> (mem_req_o.waddr != mem_req_o.raddr))
    else $error("read and write hit the same entry");

  a_pend_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(state_q) == S_SCAN))
    else $error("pending read outside a scan");

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_req_o.re)
    else $error("read issued while idle");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !res_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped before hand-off");
`endif

endmodule

[rtl/ordered_array_table_engine.sv]
`timescale 1ns / 1ps

// Ordered array of up to 16 signed words in a single-port-read, single-port-write
// memory with a registered read. One word in gives one word out. Push, the
// unused mode, deleting the last entry, inserting at the end and every word refused
// at once (full, empty, out of range, find or remove on an empty array) finish
// without a memory walk. Pop and read issue one memory read and wait for its word.
// Find, remove and delete walk the entries they cover, and insert walks the tail
// and then writes the new value in a fixup step. The walk moves one entry per cycle
// because the memory gives one read and one write each cycle. A finished result
// waits in the output register while the next word is taken in. A held output
// keeps the result waiting in the engine until the output register frees.
module ordered_array_table_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [oate_pkg::MODE_W-1:0]        mode_i,
  input  logic [oate_pkg::POS_W-1:0]         position_i,
  input  logic signed [oate_pkg::DATA_W-1:0] operand_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [oate_pkg::STATUS_W-1:0]      status_o,
  output logic signed [oate_pkg::DATA_W-1:0] read_value_o,
  output logic [oate_pkg::FPOS_W-1:0]        found_position_o,
  output logic [oate_pkg::COUNT_W-1:0]       entry_count_o
);

  oate_pkg::mem_req_t mem_req;
  oate_pkg::data_t    mem_rdata;
  oate_pkg::result_t  res, out_res_q;
  logic               res_valid, res_ready;
  logic               out_valid_q;

  oate_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  oate_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .operand_value_i (operand_value_i),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // output slot frees when empty or when its word is taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_res_q   <= res;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign read_value_o     = out_res_q.data;
  assign found_position_o = oate_pkg::FPOS_W'(out_res_q.fpos);
  assign entry_count_o    = oate_pkg::COUNT_W'(out_res_q.count);

endmodule

[verif/ordered_array_table_engine_tb.sv]
`timescale 1ns / 1ps

module ordered_array_table_engine_tb;
  import oate_pkg::*;

  // unused mode, the block answers ok with zero data
  localparam logic [MODE_W-1:0] MODE_IDLE = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int POS_MAX = (1 << POS_W) - 1;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   data;
    logic [FPOS_W-1:0]   fpos;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [4:0]        reps;
    logic              typed;
    outcome_t          want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [MODE_W-1:0] mode_r = '0;
  logic [POS_W-1:0] pos_r = '0;
  logic signed [DATA_W-1:0] value_r = '0;
  logic out_stall = 1'b0;

  logic in_stall_o;
  logic out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [FPOS_W-1:0] found_position_o;
  logic [COUNT_W-1:0] entry_count_o;

  // array contents as the block should hold them
  logic [DATA_W-1:0] slots [CAPACITY];
  int fill = 0;
  bit filling = 1'b1;

  outcome_t results_due [$];
  outcome_t head;
  row_t plan [$];

  int errors = 0;
  int checked = 0;
  int sent = 0;
  int status_seen [8];
  int hold_left = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  ordered_array_table_engine uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_r),
    .position_i      (pos_r),
    .operand_value_i (value_r),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .found_position_o(found_position_o),
    .entry_count_o   (entry_count_o)
  );

  task automatic note_error(string msg);
    errors++;
    if (errors <= 40) $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // applies one word to the array copy and returns the result it should cause
  function automatic outcome_t apply_command(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                             logic [DATA_W-1:0] val);
    outcome_t o;
    int p;
    int k;
    o = '0;
    o.status = ST_OK;
    p = int'(pos);
    case (mode)
      MODE_PUSH: begin
        if (fill >= CAPACITY) o.status = ST_FULL;
        else begin
          slots[fill] = val;
          fill++;
        end
      end
      MODE_POP: begin
        if (fill == 0) o.status = ST_EMPTY;
        else begin
          fill--;
          o.data = slots[fill];
        end
      end
      MODE_INSERT: begin
        if (p > fill) o.status = ST_RANGE;
        else if (fill >= CAPACITY) o.status = ST_FULL;
        else begin
          for (int j = fill; j > p; j--) slots[j] = slots[j-1];
          slots[p] = val;
          fill++;
        end
      end
      MODE_DELETE: begin
        if (p >= fill) o.status = ST_RANGE;
        else begin
          for (int j = p; j + 1 < fill; j++) slots[j] = slots[j+1];
          fill--;
        end
      end
      MODE_REMOVE: begin
        k = 0;
        for (int j = 0; j < fill; j++) begin
          if (slots[j] != val) begin
            slots[k] = slots[j];
            k++;
          end
        end
        if (k == fill) o.status = ST_NOTFOUND;
        fill = k;
      end
      MODE_FIND: begin
        o.status = ST_NOTFOUND;
        for (int j = 0; j < fill; j++) begin
          if (slots[j] == val && o.status == ST_NOTFOUND) begin
            o.status = ST_OK;
            o.fpos = FPOS_W'(j);
          end
        end
      end
      MODE_READ: begin
        if (p >= fill) o.status = ST_RANGE;
        else o.data = slots[p];
      end
      default: ;
    endcase
    o.count = COUNT_W'(fill);
    return o;
  endfunction

  task automatic send_command(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                              logic [DATA_W-1:0] val, logic typed, outcome_t want);
    int gap;
    outcome_t predicted;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode_r   <= mode;
    pos_r    <= pos;
    value_r  <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    predicted = apply_command(mode, pos, val);
    results_due.push_back(typed ? want : predicted);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // random words: sequences drift between filling and draining the array,
  // values often taken from the array so find and remove hit
  task automatic run_random(int n);
    int done;
    int r;
    int top;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0] pos;
    logic [DATA_W-1:0] val;
    done = 0;
    while (done < n) begin
      if (fill >= CAPACITY) filling = 1'b0;
      else if (fill == 0) filling = 1'b1;
      else if ($urandom_range(0, 19) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (r < 2) mode = MODE_IDLE;
      else if (r < 45) begin
        if (filling) mode = $urandom_range(0, 1) ? MODE_PUSH : MODE_INSERT;
        else mode = $urandom_range(0, 1) ? MODE_POP : MODE_DELETE;
      end else mode = MODE_W'($urandom_range(int'(MODE_PUSH), int'(MODE_READ)));
      top = (mode == MODE_INSERT) ? fill : fill - 1;
      if (top > POS_MAX) top = POS_MAX;
      if (top < 0) top = 0;
      if ($urandom_range(0, 3) != 0) pos = POS_W'($urandom_range(0, top));
      else pos = POS_W'($urandom_range(0, POS_MAX));
      r = $urandom_range(0, 99);
      if (r < 45 && fill > 0) val = slots[$urandom_range(0, fill - 1)];
      else if (r < 70) val = DATA_W'($urandom_range(0, 3));
      else if (r < 76) val = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      else val = $urandom();
      send_command(mode, pos, val, 1'b0, '0);
      if (mode != MODE_IDLE) done++;
    end
  endtask

  function automatic row_t plan_row(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                    logic [DATA_W-1:0] val, int reps, logic typed,
                                    status_e st, logic [DATA_W-1:0] data,
                                    logic [FPOS_W-1:0] fpos, logic [COUNT_W-1:0] cnt);
    row_t row;
    row.mode = mode;
    row.pos = pos;
    row.val = val;
    row.reps = 5'(reps);
    row.typed = typed;
    row.want.status = st;
    row.want.data = data;
    row.want.fpos = fpos;
    row.want.count = cnt;
    return row;
  endfunction

  // receiver: random stalls, or the long hold when asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (quiet || stall_left == 0) begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end else begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      if (results_due.size() == 0) begin
        note_error("result word with nothing outstanding");
      end else begin
        head = results_due.pop_front();
        checked++;
        status_seen[head.status]++;
        if (status_o !== head.status)
          note_error($sformatf("word %0d: status %0d, want %0d", checked, status_o, head.status));
        if (read_value_o !== head.data)
          note_error($sformatf("word %0d: data %h, want %h", checked, read_value_o, head.data));
        if (found_position_o !== head.fpos)
          note_error($sformatf("word %0d: index %0d, want %0d", checked, found_position_o,
                               head.fpos));
        if (entry_count_o !== head.count)
          note_error($sformatf("word %0d: count %0d, want %0d", checked, entry_count_o,
                               head.count));
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d results outstanding", results_due.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    // empty array corner cases first, then words on a two-entry array
    plan.push_back(plan_row(MODE_POP, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0));
    plan.push_back(plan_row(MODE_READ, 0, 0, 1, 1, ST_RANGE, 0, 0, 0));
    plan.push_back(plan_row(MODE_REMOVE, 0, 5, 1, 1, ST_NOTFOUND, 0, 0, 0));
    plan.push_back(plan_row(MODE_FIND, 0, 5, 1, 1, ST_NOTFOUND, 0, 0, 0));
    plan.push_back(plan_row(MODE_INSERT, 1, 9, 1, 1, ST_RANGE, 0, 0, 0));
    plan.push_back(plan_row(MODE_INSERT, 0, 32'h7fff_ffff, 1, 1, ST_OK, 0, 0, 1));
    plan.push_back(plan_row(MODE_PUSH, 0, 32'h8000_0000, 1, 1, ST_OK, 0, 0, 2));
    plan.push_back(plan_row(MODE_READ, 1, 0, 1, 1, ST_OK, 32'h8000_0000, 0, 2));
    plan.push_back(plan_row(MODE_FIND, 0, 32'h8000_0000, 1, 1, ST_OK, 0, 1, 2));
    plan.push_back(plan_row(MODE_IDLE, 15, 32'hffff_ffff, 1, 1, ST_OK, 0, 0, 2));
    // fill up with duplicates, then full, remove and drain cases
    plan.push_back(plan_row(MODE_PUSH, 0, 5, 14, 0, ST_OK, 0, 0, 0));
    plan.push_back(plan_row(MODE_PUSH, 0, 32'hffff_ffff, 1, 1, ST_FULL, 0, 0, 16));
    plan.push_back(plan_row(MODE_INSERT, 15, 0, 1, 1, ST_FULL, 0, 0, 16));
    plan.push_back(plan_row(MODE_READ, 15, 0, 1, 0, ST_OK, 0, 0, 0));
    plan.push_back(plan_row(MODE_REMOVE, 0, 5, 1, 1, ST_OK, 0, 0, 2));
    plan.push_back(plan_row(MODE_DELETE, 2, 0, 1, 1, ST_RANGE, 0, 0, 2));
    plan.push_back(plan_row(MODE_POP, 0, 0, 1, 1, ST_OK, 32'h8000_0000, 0, 1));
    plan.push_back(plan_row(MODE_POP, 0, 0, 1, 1, ST_OK, 32'h7fff_ffff, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++)
        send_command(plan[i].mode, plan[i].pos, plan[i].val, plan[i].typed, plan[i].want);
    end
    wait_drained();

    run_random(300);
    wait_drained();

    // output held off while words keep coming, then a stretch with no idling
    quiet = 1'b1;
    hold_left = HOLD_CYCLES;
    run_random(240);
    quiet = 1'b0;
    wait_drained();

    run_random(280);
    wait_drained();
    repeat (40) @(posedge clk);

    $display("%0d words sent, %0d results checked, long output hold and no-idle stretch run",
             sent, checked);
    $display("status mix: ok %0d, full %0d, empty %0d, range %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_RANGE], status_seen[ST_NOTFOUND]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/oate_pkg.sv
rtl/oate_mem.sv
rtl/oate_ctrl.sv
rtl/ordered_array_table_engine.sv
verif/ordered_array_table_engine_tb.sv
